### hdl/gpe_pkg.sv
// Shared codes for the gate position estimator: item kinds, gate statuses, motions, commands.
package gpe_pkg;

    // Item kinds carried on the input channel
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_STATUS  = 2'd1;
    localparam logic [1:0] MODE_REQUEST = 2'd2;
    localparam logic [1:0] MODE_STOP    = 2'd3;

    // Gate status codes as reported by the gate unit
    localparam logic [2:0] ST_PAUSED  = 3'd0;
    localparam logic [2:0] ST_CLOSED  = 3'd1;
    localparam logic [2:0] ST_OPENED  = 3'd2;
    localparam logic [2:0] ST_OPENING = 3'd3;
    localparam logic [2:0] ST_CLOSING = 3'd4;
    localparam logic [2:0] ST_OTHER   = 3'd5;

    // Motion codes
    localparam logic [1:0] MOT_IDLE    = 2'd0;
    localparam logic [1:0] MOT_OPENING = 2'd1;
    localparam logic [1:0] MOT_CLOSING = 2'd2;

    // Gate commands
    localparam logic [1:0] CMD_PAUSE = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_OPEN_MS  = 1'b0;
    localparam logic CFG_CLOSE_MS = 1'b1;

    // Reset run duration in milliseconds
    localparam int unsigned RESET_RUN_MS = 15000;

endpackage

### hdl/gpe_step_div.sv
// Iterative restoring divider: step = (diff * POS_MAX + dur / 2) / dur, saturated to POS_MAX.
module gpe_step_div #(
    parameter int POSITION_BITS = 16,
    parameter int DURATION_BITS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [31:0]              diff,
    input  logic [DURATION_BITS-1:0] dur,
    output logic                     done,
    output logic [POSITION_BITS-1:0] step
);
    import gpe_pkg::*;

    localparam int P  = POSITION_BITS;
    localparam int DB = DURATION_BITS;
    localparam int NW = 32 + P + 1;     // numerator incl. rounding carry
    localparam int HW = NW - P;         // high part compared against the divisor
    localparam int CW = $clog2(P + 1);

    typedef enum logic [4:0] {
        DV_IDLE  = 5'b00001,
        DV_PROD  = 5'b00010,
        DV_ADD   = 5'b00100,
        DV_CHECK = 5'b01000,
        DV_ITER  = 5'b10000
    } dv_state_t;

    dv_state_t       state_reg, state_next;
    logic [31:0]     diff_reg, diff_next;
    logic [DB-1:0]   dur_reg, dur_next;
    logic [NW-1:0]   numer_reg, numer_next;
    logic [DB-1:0]   rem_reg, rem_next;
    logic [P-1:0]    quo_reg, quo_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            done_reg, done_next;

    logic [HW-1:0]   hi;
    logic [DB:0]     trial;
    logic            fits;

    assign hi    = numer_reg[NW-1:P];
    assign trial = {rem_reg, numer_reg[P-1]};
    assign fits  = trial >= {1'b0, dur_reg};

    always_comb begin
        state_next = state_reg;
        diff_next  = diff_reg;
        dur_next   = dur_reg;
        numer_next = numer_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            DV_IDLE: begin
                if (start) begin
                    diff_next  = diff;
                    dur_next   = dur;
                    state_next = DV_PROD;
                end
            end
            DV_PROD: begin
                // diff * (2^P - 1) as shift and subtract
                numer_next = {1'b0, diff_reg, {P{1'b0}}} - {{(P + 1){1'b0}}, diff_reg};
                state_next = DV_ADD;
            end
            DV_ADD: begin
                numer_next = numer_reg + {{(NW - DB + 1){1'b0}}, dur_reg[DB-1:1]};
                state_next = DV_CHECK;
            end
            DV_CHECK: begin
                // quotient beyond P bits (or zero divisor): saturate at once
                if (hi >= {{(HW - DB){1'b0}}, dur_reg}) begin
                    quo_next   = {P{1'b1}};
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end else begin
                    rem_next   = hi[DB-1:0];
                    quo_next   = '0;
                    cnt_next   = CW'(P);
                    state_next = DV_ITER;
                end
            end
            DV_ITER: begin
                rem_next   = fits ? trial[DB-1:0] - dur_reg : trial[DB-1:0];
                quo_next   = {quo_reg[P-2:0], fits};
                numer_next = {numer_reg[NW-2:0], 1'b0};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end
            end
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
        diff_reg  <= diff_next;
        dur_reg   <= dur_next;
        numer_reg <= numer_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    assign done = done_reg;
    assign step = quo_reg;

endmodule

### hdl/gate_position_estimator.sv
// Top level of the gate position estimator: item sequencer, gate state and result register.
// While the gate moves, a request passes the action, divide, apply, check and finish states, and
// the divider stops early when the step saturates; when it stands idle the divider is skipped.
// A new request is taken only once the last result is handed on, the single divider producing
// one quotient bit per cycle; s_ready is low meanwhile.
// Reset: synchronous, active low; gate closed, status unknown, run durations 15000 ms.
module gate_position_estimator #(
    parameter int POSITION_BITS = 16,
    parameter int DURATION_BITS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration write port
    input  logic                     cfg_we,
    input  logic                     cfg_addr,
    input  logic [DURATION_BITS-1:0] cfg_wdata,
    // request channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_mode,
    input  logic [31:0]              s_now_ms,
    input  logic [2:0]               s_new_status,
    input  logic [POSITION_BITS-1:0] s_target_position,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_command_valid,
    output logic [1:0]               m_command_code,
    output logic [POSITION_BITS-1:0] m_position_estimate,
    output logic [1:0]               m_motion,
    output logic [DURATION_BITS-1:0] m_open_time_ms,
    output logic [DURATION_BITS-1:0] m_close_time_ms
);
    import gpe_pkg::*;

    localparam int P  = POSITION_BITS;
    localparam int DB = DURATION_BITS;
    localparam logic [P-1:0]  POS_MAX   = {P{1'b1}};
    localparam logic [DB-1:0] DUR_MAX   = {DB{1'b1}};
    localparam logic [31:0]   DUR_MAX32 = 32'((64'd1 << DB) - 64'd1);
    localparam logic [DB-1:0] DUR_RESET = DB'(RESET_RUN_MS);

    // Sequencer: take the item's own action, run the divider and apply the step while the gate
    // moves, check a pending midpoint, then hand the result to the output register.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ACTION = 6'b000010,
        S_DIVIDE = 6'b000100,
        S_APPLY  = 6'b001000,
        S_CHECK  = 6'b010000,
        S_FINISH = 6'b100000
    } seq_state_t;

    seq_state_t     state_reg, state_next;

    // latched request
    logic [1:0]     mode_reg, mode_next;
    logic [31:0]    now_reg, now_next;
    logic [2:0]     status_reg, status_next;
    logic [P-1:0]   target_reg, target_next;

    // gate state
    logic [P-1:0]   gate_pos_reg, gate_pos_next;
    logic [2:0]     last_status_reg, last_status_next;
    logic [1:0]     motion_reg, motion_next;
    logic [P-1:0]   stop_target_reg, stop_target_next;
    logic           stop_valid_reg, stop_valid_next;
    logic [DB-1:0]  open_time_reg, open_time_next;
    logic [DB-1:0]  close_time_reg, close_time_next;
    logic [31:0]    run_start_reg, run_start_next;
    logic           run_valid_reg, run_valid_next;
    logic [31:0]    last_update_reg, last_update_next;
    logic           cmd_valid_reg, cmd_valid_next;
    logic [1:0]     cmd_code_reg, cmd_code_next;
    logic           div_start_reg, div_start_next;

    // result register
    logic           m_valid_reg, m_valid_next;
    logic           m_command_valid_reg, m_command_valid_next;
    logic [1:0]     m_command_code_reg, m_command_code_next;
    logic [P-1:0]   m_position_reg, m_position_next;
    logic [1:0]     m_motion_reg, m_motion_next;
    logic [DB-1:0]  m_open_reg, m_open_next;
    logic [DB-1:0]  m_close_reg, m_close_next;

    logic           div_done;
    logic [P-1:0]   div_step;
    logic [31:0]    div_diff;
    logic [DB-1:0]  div_dur;
    logic [31:0]    run_dt;
    logic [DB-1:0]  run_dt_sat;
    logic [P:0]     pos_sum;
    logic           accept;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);

    // divider operands come from registered state, valid in the cycle after the action
    assign div_diff = now_reg - last_update_reg;
    assign div_dur  = (motion_reg == MOT_CLOSING) ? close_time_reg : open_time_reg;

    // measured run time, held to 1 .. DUR_MAX
    assign run_dt = now_reg - run_start_reg;
    always_comb begin
        priority if (run_dt == 32'd0) begin
            run_dt_sat = DB'(1);
        end else if (run_dt > DUR_MAX32) begin
            run_dt_sat = DUR_MAX;
        end else begin
            run_dt_sat = run_dt[DB-1:0];
        end
    end

    assign pos_sum = {1'b0, gate_pos_reg} + {1'b0, div_step};

    gpe_step_div #(
        .POSITION_BITS (P),
        .DURATION_BITS (DB)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .diff    (div_diff),
        .dur     (div_dur),
        .done    (div_done),
        .step    (div_step)
    );

    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        now_next         = now_reg;
        status_next      = status_reg;
        target_next      = target_reg;
        gate_pos_next    = gate_pos_reg;
        last_status_next = last_status_reg;
        motion_next      = motion_reg;
        stop_target_next = stop_target_reg;
        stop_valid_next  = stop_valid_reg;
        open_time_next   = open_time_reg;
        close_time_next  = close_time_reg;
        run_start_next   = run_start_reg;
        run_valid_next   = run_valid_reg;
        last_update_next = last_update_reg;
        cmd_valid_next   = cmd_valid_reg;
        cmd_code_next    = cmd_code_reg;
        div_start_next   = 1'b0;

        // hold the result until taken
        m_valid_next         = m_valid_reg && !m_ready;
        m_command_valid_next = m_command_valid_reg;
        m_command_code_next  = m_command_code_reg;
        m_position_next      = m_position_reg;
        m_motion_next        = m_motion_reg;
        m_open_next          = m_open_reg;
        m_close_next         = m_close_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mode_next   = s_mode;
                    now_next    = s_now_ms;
                    // fold the unused status codes onto "other"
                    status_next = (s_new_status > ST_OTHER) ? ST_OTHER : s_new_status;
                    target_next = s_target_position;
                    state_next  = S_ACTION;
                end
            end
            S_ACTION: begin
                cmd_valid_next = 1'b0;
                cmd_code_next  = CMD_PAUSE;
                unique case (mode_reg)
                    MODE_STATUS: begin
                        if (status_reg != last_status_reg) begin
                            // recalibrate on a completed run from an end stop
                            priority if (status_reg == ST_PAUSED) begin
                                run_valid_next = 1'b0;
                            end else if ((last_status_reg == ST_CLOSED &&
                                          status_reg == ST_OPENING) ||
                                         (last_status_reg == ST_OPENED &&
                                          status_reg == ST_CLOSING)) begin
                                run_start_next = now_reg;
                                run_valid_next = 1'b1;
                            end else if (run_valid_reg) begin
                                if (status_reg == ST_OPENED) open_time_next = run_dt_sat;
                                if (status_reg == ST_CLOSED) close_time_next = run_dt_sat;
                                run_valid_next = 1'b0;
                            end
                            // snap at the end stops; pause after a full open
                            priority if (status_reg == ST_OPENED) begin
                                cmd_valid_next = 1'b1;
                                cmd_code_next  = CMD_PAUSE;
                                gate_pos_next  = POS_MAX;
                            end else if (status_reg == ST_CLOSED) begin
                                gate_pos_next = '0;
                            end
                            last_status_next = status_reg;
                            priority if (status_reg == ST_OPENING) begin
                                motion_next = MOT_OPENING;
                            end else if (status_reg == ST_CLOSING) begin
                                motion_next = MOT_CLOSING;
                            end else begin
                                motion_next = MOT_IDLE;
                            end
                            last_update_next = now_reg;
                        end
                    end
                    MODE_REQUEST: begin
                        if (target_reg != gate_pos_reg) begin
                            cmd_valid_next = 1'b1;
                            priority if (target_reg == POS_MAX) begin
                                cmd_code_next = CMD_OPEN;
                            end else if (target_reg == '0) begin
                                cmd_code_next = CMD_CLOSE;
                            end else begin
                                // midpoint: remember where to pause
                                stop_target_next = target_reg;
                                stop_valid_next  = 1'b1;
                                cmd_code_next    = (target_reg > gate_pos_reg) ? CMD_OPEN
                                                                               : CMD_CLOSE;
                            end
                        end
                    end
                    MODE_STOP: begin
                        cmd_valid_next = 1'b1;
                        cmd_code_next  = CMD_PAUSE;
                    end
                    MODE_TICK: begin
                    end
                    default: begin
                    end
                endcase
                if (motion_next != MOT_IDLE) begin
                    div_start_next = 1'b1;
                    state_next     = S_DIVIDE;
                end else begin
                    state_next = S_CHECK;
                end
            end
            S_DIVIDE: begin
                if (div_done) state_next = S_APPLY;
            end
            S_APPLY: begin
                // advance and clamp at the end stops
                if (motion_reg == MOT_CLOSING) begin
                    gate_pos_next = (div_step >= gate_pos_reg) ? '0 : gate_pos_reg - div_step;
                end else begin
                    gate_pos_next = pos_sum[P] ? POS_MAX : pos_sum[P-1:0];
                end
                last_update_next = now_reg;
                state_next       = S_CHECK;
            end
            S_CHECK: begin
                // pause once the requested midpoint is reached or passed
                if (motion_reg != MOT_IDLE && stop_valid_reg) begin
                    if (!((motion_reg == MOT_OPENING && gate_pos_reg < stop_target_reg) ||
                          (motion_reg == MOT_CLOSING && gate_pos_reg > stop_target_reg))) begin
                        cmd_valid_next  = 1'b1;
                        cmd_code_next   = CMD_PAUSE;
                        stop_valid_next = 1'b0;
                    end
                end
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_command_valid_next = cmd_valid_reg;
                    m_command_code_next  = cmd_valid_reg ? cmd_code_reg : CMD_PAUSE;
                    m_position_next      = gate_pos_reg;
                    m_motion_next        = motion_reg;
                    m_open_next          = open_time_reg;
                    m_close_next         = close_time_reg;
                    state_next           = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // a register write also sets the current duration
        if (cfg_we) begin
            if (cfg_addr == CFG_OPEN_MS) begin
                open_time_next = cfg_wdata;
            end else begin
                close_time_next = cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            gate_pos_reg    <= '0;
            last_status_reg <= ST_OTHER;
            motion_reg      <= MOT_IDLE;
            stop_target_reg <= '0;
            stop_valid_reg  <= 1'b0;
            open_time_reg   <= DUR_RESET;
            close_time_reg  <= DUR_RESET;
            run_start_reg   <= '0;
            run_valid_reg   <= 1'b0;
            last_update_reg <= '0;
            cmd_valid_reg   <= 1'b0;
            cmd_code_reg    <= CMD_PAUSE;
            div_start_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            gate_pos_reg    <= gate_pos_next;
            last_status_reg <= last_status_next;
            motion_reg      <= motion_next;
            stop_target_reg <= stop_target_next;
            stop_valid_reg  <= stop_valid_next;
            open_time_reg   <= open_time_next;
            close_time_reg  <= close_time_next;
            run_start_reg   <= run_start_next;
            run_valid_reg   <= run_valid_next;
            last_update_reg <= last_update_next;
            cmd_valid_reg   <= cmd_valid_next;
            cmd_code_reg    <= cmd_code_next;
            div_start_reg   <= div_start_next;
            m_valid_reg     <= m_valid_next;
        end
        mode_reg            <= mode_next;
        now_reg             <= now_next;
        status_reg          <= status_next;
        target_reg          <= target_next;
        m_command_valid_reg <= m_command_valid_next;
        m_command_code_reg  <= m_command_code_next;
        m_position_reg      <= m_position_next;
        m_motion_reg        <= m_motion_next;
        m_open_reg          <= m_open_next;
        m_close_reg         <= m_close_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_command_valid     = m_command_valid_reg;
    assign m_command_code      = m_command_code_reg;
    assign m_position_estimate = m_position_reg;
    assign m_motion            = m_motion_reg;
    assign m_open_time_ms      = m_open_reg;
    assign m_close_time_ms     = m_close_reg;

endmodule

### hdl/gpe_checker.sv
// Port-level checks for the gate position estimator, bound to its top level.
module gpe_checker #(
    parameter int POSITION_BITS = 16,
    parameter int DURATION_BITS = 24
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic                     m_command_valid,
    input logic [1:0]               m_command_code,
    input logic [POSITION_BITS-1:0] m_position_estimate,
    input logic [1:0]               m_motion,
    input logic [DURATION_BITS-1:0] m_open_time_ms
);
    import gpe_pkg::*;

    // one request at a time: the block goes busy straight after taking one
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while the previous one is in progress");

    // no command means a zero code
    a_code_without_command: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_command_valid) |-> (m_command_code == CMD_PAUSE))
        else $error("command code set without a command");

    // the motion field carries only defined motions
    a_motion_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_motion == MOT_IDLE || m_motion == MOT_OPENING ||
                     m_motion == MOT_CLOSING))
        else $error("undefined motion code in result");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_position_estimate) &&
                                   $stable(m_open_time_ms)))
        else $error("stalled result changed");

endmodule

bind gate_position_estimator gpe_checker #(
    .POSITION_BITS (POSITION_BITS),
    .DURATION_BITS (DURATION_BITS)
) u_gpe_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_command_valid     (m_command_valid),
    .m_command_code      (m_command_code),
    .m_position_estimate (m_position_estimate),
    .m_motion            (m_motion),
    .m_open_time_ms      (m_open_time_ms)
);

### tb/gpe_result_checker.sv
// Result checker for the gate position estimator: predicts every result and compares it.
`timescale 1ns / 1ps
module gpe_result_checker #(
    parameter int POSITION_BITS = 16,
    parameter int DURATION_BITS = 24
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic                     cfg_addr,
    input  logic [DURATION_BITS-1:0] cfg_wdata,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [1:0]               s_mode,
    input  logic [31:0]              s_now_ms,
    input  logic [2:0]               s_new_status,
    input  logic [POSITION_BITS-1:0] s_target_position,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic                     m_command_valid,
    input  logic [1:0]               m_command_code,
    input  logic [POSITION_BITS-1:0] m_position_estimate,
    input  logic [1:0]               m_motion,
    input  logic [DURATION_BITS-1:0] m_open_time_ms,
    input  logic [DURATION_BITS-1:0] m_close_time_ms,
    output int                       mismatch_count,
    output int                       estimates_due
);
    import gpe_pkg::*;

    localparam longint unsigned POS_MAX = (64'd1 << POSITION_BITS) - 64'd1;
    localparam longint unsigned DUR_MAX = (64'd1 << DURATION_BITS) - 64'd1;

    typedef struct packed {
        logic                     cmd_valid;
        logic [1:0]               cmd_code;
        logic [POSITION_BITS-1:0] position;
        logic [1:0]               motion;
        logic [DURATION_BITS-1:0] open_ms;
        logic [DURATION_BITS-1:0] close_ms;
    } gate_estimate_t;

    gate_estimate_t predicted_estimates[$];
    gate_estimate_t oldest;

    // Own copy of the gate state
    logic [POSITION_BITS-1:0] position;
    logic [2:0]               gate_status;
    logic [1:0]               motion;
    logic [POSITION_BITS-1:0] pause_at;
    logic                     pause_armed;
    logic [DURATION_BITS-1:0] open_run_ms;
    logic [DURATION_BITS-1:0] close_run_ms;
    logic [31:0]              run_start_ms;
    logic                     run_timed;
    logic [31:0]              last_move_ms;

    function automatic logic [DURATION_BITS-1:0] measured_run(input logic [31:0] span);
        logic [DURATION_BITS-1:0] d;
        if (span == 32'd0) d = DURATION_BITS'(1);
        else if (64'(span) > DUR_MAX) d = '1;
        else d = span[DURATION_BITS-1:0];
        return d;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatch_count++;
        $display("mismatch in %s at %0t: got %0h, want %0h", what, $time, got, want);
    endtask

    task automatic estimate_gate(input logic [1:0] mode, input logic [31:0] now,
                                 input logic [2:0] status_in,
                                 input logic [POSITION_BITS-1:0] target);
        logic [2:0]        st;
        logic              cmd_v;
        logic [1:0]        cmd_c;
        logic [31:0]       elapsed;
        longint unsigned   span;
        longint unsigned   dur;
        longint unsigned   step;
        longint unsigned   sum;
        gate_estimate_t    est;
        st    = (status_in > ST_OTHER) ? ST_OTHER : status_in;
        cmd_v = 1'b0;
        cmd_c = CMD_PAUSE;
        case (mode)
            MODE_STATUS: begin
                if (st != gate_status) begin
                    // recalibrate on a completed full run
                    if (st == ST_PAUSED) begin
                        run_timed = 1'b0;
                    end else if ((gate_status == ST_CLOSED && st == ST_OPENING) ||
                                 (gate_status == ST_OPENED && st == ST_CLOSING)) begin
                        run_start_ms = now;
                        run_timed    = 1'b1;
                    end else if (run_timed) begin
                        if (st == ST_OPENED) open_run_ms = measured_run(now - run_start_ms);
                        if (st == ST_CLOSED) close_run_ms = measured_run(now - run_start_ms);
                        run_timed = 1'b0;
                    end
                    if (st == ST_OPENED) begin
                        cmd_v    = 1'b1;
                        cmd_c    = CMD_PAUSE;
                        position = '1;
                    end else if (st == ST_CLOSED) begin
                        position = '0;
                    end
                    gate_status = st;
                    case (st)
                        ST_OPENING: motion = MOT_OPENING;
                        ST_CLOSING: motion = MOT_CLOSING;
                        default:    motion = MOT_IDLE;
                    endcase
                    last_move_ms = now;
                end
            end
            MODE_REQUEST: begin
                if (target != position) begin
                    cmd_v = 1'b1;
                    if (target == '1) begin
                        cmd_c = CMD_OPEN;
                    end else if (target == '0) begin
                        cmd_c = CMD_CLOSE;
                    end else begin
                        pause_at    = target;
                        pause_armed = 1'b1;
                        cmd_c       = (target > position) ? CMD_OPEN : CMD_CLOSE;
                    end
                end
            end
            MODE_STOP: begin
                cmd_v = 1'b1;
                cmd_c = CMD_PAUSE;
            end
            default: ;
        endcase

        // advance by elapsed time over the run duration
        if (motion != MOT_IDLE) begin
            elapsed = now - last_move_ms;
            span    = 64'(elapsed);
            dur     = 64'((motion == MOT_CLOSING) ? close_run_ms : open_run_ms);
            if (dur == 64'd0) begin
                step = POS_MAX;
            end else begin
                step = (span * POS_MAX + dur / 64'd2) / dur;
                if (step > POS_MAX) step = POS_MAX;
            end
            if (motion == MOT_CLOSING) begin
                position = (step >= 64'(position)) ? '0 : position - step[POSITION_BITS-1:0];
            end else begin
                sum      = 64'(position) + step;
                position = (sum > POS_MAX) ? '1 : sum[POSITION_BITS-1:0];
            end
            last_move_ms = now;
        end

        // pause once the midpoint is reached or passed
        if (motion != MOT_IDLE && pause_armed) begin
            if ((motion == MOT_OPENING && position >= pause_at) ||
                (motion == MOT_CLOSING && position <= pause_at)) begin
                cmd_v       = 1'b1;
                cmd_c       = CMD_PAUSE;
                pause_armed = 1'b0;
            end
        end

        est.cmd_valid = cmd_v;
        est.cmd_code  = cmd_v ? cmd_c : CMD_PAUSE;
        est.position  = position;
        est.motion    = motion;
        est.open_ms   = open_run_ms;
        est.close_ms  = close_run_ms;
        predicted_estimates.push_back(est);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            position     = '0;
            gate_status  = ST_OTHER;
            motion       = MOT_IDLE;
            pause_at     = '0;
            pause_armed  = 1'b0;
            open_run_ms  = DURATION_BITS'(RESET_RUN_MS);
            close_run_ms = DURATION_BITS'(RESET_RUN_MS);
            run_start_ms = '0;
            run_timed    = 1'b0;
            last_move_ms = '0;
            predicted_estimates.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_OPEN_MS) open_run_ms = cfg_wdata;
                else close_run_ms = cfg_wdata;
            end
            if (m_valid && m_ready) begin
                if (predicted_estimates.size() == 0) begin
                    report_mismatch("result with no request outstanding", 0, 0);
                end else begin
                    oldest = predicted_estimates.pop_front();
                    if (m_command_valid !== oldest.cmd_valid)
                        report_mismatch("command_valid", m_command_valid, oldest.cmd_valid);
                    if (m_command_code !== oldest.cmd_code)
                        report_mismatch("command_code", m_command_code, oldest.cmd_code);
                    if (m_position_estimate !== oldest.position)
                        report_mismatch("position_estimate", m_position_estimate,
                                        oldest.position);
                    if (m_motion !== oldest.motion)
                        report_mismatch("motion", m_motion, oldest.motion);
                    if (m_open_time_ms !== oldest.open_ms)
                        report_mismatch("open_time_ms", m_open_time_ms, oldest.open_ms);
                    if (m_close_time_ms !== oldest.close_ms)
                        report_mismatch("close_time_ms", m_close_time_ms, oldest.close_ms);
                end
            end
            if (s_valid && s_ready)
                estimate_gate(s_mode, s_now_ms, s_new_status, s_target_position);
        end
        estimates_due <= predicted_estimates.size();
    end

endmodule

### tb/gate_position_estimator_test.sv
// Top of the gate position estimator testbench: stimulus, idling, pressure and the verdict.
`timescale 1ns / 1ps
module gate_position_estimator_test;
    import gpe_pkg::*;

    localparam int POSITION_BITS = 16;
    localparam int DURATION_BITS = 24;
    localparam logic [DURATION_BITS-1:0] DUR_MAX = '1;
    localparam logic [POSITION_BITS-1:0] FULL_OPEN = '1;
    // Settling wait before touching the registers or ending, scaled with POSITION_BITS
    localparam int HOLD_OFF = 2 * (POSITION_BITS + 10);
    // Cycle limit for the watchdog
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES = 8;
    localparam int PHASE_REQUESTS = 110;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    logic                     cfg_addr = CFG_OPEN_MS;
    logic [DURATION_BITS-1:0] cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_mode = MODE_TICK;
    logic [31:0]              s_now_ms = '0;
    logic [2:0]               s_new_status = ST_OTHER;
    logic [POSITION_BITS-1:0] s_target_position = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_command_valid;
    logic [1:0]               m_command_code;
    logic [POSITION_BITS-1:0] m_position_estimate;
    logic [1:0]               m_motion;
    logic [DURATION_BITS-1:0] m_open_time_ms;
    logic [DURATION_BITS-1:0] m_close_time_ms;

    int          mismatch_count;
    int          estimates_due;
    int          cycle_count = 0;
    int          requests_sent = 0;
    int unsigned clock_ms = 0;
    // When set, neither side idles: back-to-back requests and results
    bit          steady_flow = 1'b0;

    gate_position_estimator #(
        .POSITION_BITS(POSITION_BITS),
        .DURATION_BITS(DURATION_BITS)
    ) dut (.*);

    gpe_result_checker #(
        .POSITION_BITS(POSITION_BITS),
        .DURATION_BITS(DURATION_BITS)
    ) checker_inst (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // Watchdog: end the run if it hangs
    initial begin
        wait (cycle_count == LIMIT_CYCLES);
        $display("simulation failed");
        $finish;
    end

    // Offer one request: idle for a random gap, then hold valid until it is taken
    task automatic send_request(input logic [1:0] mode, input logic [31:0] now,
                                input logic [2:0] status,
                                input logic [POSITION_BITS-1:0] target);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_mode            <= mode;
        s_now_ms          <= now;
        s_new_status      <= status;
        s_target_position <= target;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
    endtask

    task automatic send_status(input logic [2:0] status);
        send_request(MODE_STATUS, clock_ms, status, POSITION_BITS'($urandom));
    endtask

    // Drop valid and hold until every predicted result has come, then let the block settle
    task automatic settle_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (estimates_due != 0) @(posedge aclk);
        repeat (HOLD_OFF) @(posedge aclk);
    endtask

    // Write both run durations, open then close; call only with the block idle
    task automatic set_run_durations(input logic [DURATION_BITS-1:0] open_ms,
                                     input logic [DURATION_BITS-1:0] close_ms);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_OPEN_MS;
        cfg_wdata <= open_ms;
        @(posedge aclk);
        cfg_addr  <= CFG_CLOSE_MS;
        cfg_wdata <= close_ms;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // One run from an end stop to the other, spread over a few steps, with the odd
    // position request, stop or pause on the way
    task automatic send_run(input bit opening, input int unsigned run_ms);
        int                       parts;
        int                       pick;
        longint unsigned          total;
        logic [POSITION_BITS-1:0] aim;
        send_status(opening ? ST_OPENING : ST_CLOSING);
        parts = $urandom_range(1, 6);
        total = 64'(run_ms);
        total = total * 64'($urandom_range(70, 130)) / 64'd100;
        repeat (parts) begin
            clock_ms += 32'(total / 64'(parts));
            pick = $urandom_range(0, 9);
            if (pick <= 1) begin
                case ($urandom_range(0, 7))
                    0:       aim = '0;
                    1:       aim = FULL_OPEN;
                    default: aim = POSITION_BITS'($urandom);
                endcase
                send_request(MODE_REQUEST, clock_ms, 3'($urandom_range(0, 7)), aim);
            end else if (pick == 2) begin
                send_request(MODE_STOP, clock_ms, 3'($urandom_range(0, 7)),
                             POSITION_BITS'($urandom));
            end else if (pick == 3) begin
                // pause mid-run and resume; this drops the calibration of the run
                send_status(ST_PAUSED);
                send_status(opening ? ST_OPENING : ST_CLOSING);
            end else begin
                send_request(MODE_TICK, clock_ms, 3'($urandom_range(0, 7)),
                             POSITION_BITS'($urandom));
            end
        end
        clock_ms += $urandom_range(0, 3);
        send_status(opening ? ST_OPENED : ST_CLOSED);
    endtask

    // Noise: any mode, any status code, sometimes a wild time stamp
    task automatic send_noise();
        logic [POSITION_BITS-1:0] aim;
        if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
        else clock_ms += $urandom_range(0, 2000);
        case ($urandom_range(0, 5))
            0:       aim = '0;
            1:       aim = FULL_OPEN;
            default: aim = POSITION_BITS'($urandom);
        endcase
        send_request(2'($urandom_range(0, 3)), clock_ms, 3'($urandom_range(0, 7)), aim);
    endtask

    // Result side: stall for a random number of cycles before taking each result
    initial begin : result_sink
        int stall;
        wait (aresetn);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin : stimulus
        int                       phase;
        int                       phase_start;
        logic [DURATION_BITS-1:0] open_ms;
        logic [DURATION_BITS-1:0] close_ms;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset durations of 15000 ms
        // tick while idle, request of the current position (no command), full open request
        send_request(MODE_TICK, 32'd0, ST_PAUSED, '0);
        send_request(MODE_REQUEST, 32'd0, ST_OTHER, '0);
        send_request(MODE_REQUEST, 32'd50, ST_OTHER, FULL_OPEN);
        // timed open run with a midpoint that is overrun, then a stop
        send_request(MODE_STATUS, 32'd100, ST_CLOSED, '0);
        send_request(MODE_STATUS, 32'd1000, ST_OPENING, '0);
        send_request(MODE_TICK, 32'd8500, ST_OTHER, '0);
        send_request(MODE_REQUEST, 32'd8500, ST_OTHER, 16'hC000);
        send_request(MODE_TICK, 32'd14000, ST_OTHER, '0);
        send_request(MODE_STOP, 32'd14100, ST_OTHER, '0);
        // full open recalibrates and pauses; full request at the end stop sends nothing
        send_request(MODE_STATUS, 32'd16000, ST_OPENED, '0);
        send_request(MODE_REQUEST, 32'd16000, ST_OTHER, FULL_OPEN);
        // closing run; a midpoint already passed gives a command and an immediate pause
        send_request(MODE_STATUS, 32'd17000, ST_CLOSING, '0);
        send_request(MODE_REQUEST, 32'd18000, ST_OTHER, 16'hFA00);
        send_request(MODE_REQUEST, 32'd19000, ST_OTHER, '0);
        send_request(MODE_TICK, 32'd33000, ST_OTHER, '0);
        send_request(MODE_STATUS, 32'd33000, ST_CLOSED, '0);
        // unknown status code, then paused
        send_request(MODE_STATUS, 32'd34000, 3'd6, '0);
        send_request(MODE_STATUS, 32'd35000, ST_PAUSED, '0);
        // zero-length open run saturates to one, a very long close run to the maximum
        send_request(MODE_STATUS, 32'd36000, ST_CLOSED, '0);
        send_request(MODE_STATUS, 32'd36000, ST_OPENING, '0);
        send_request(MODE_STATUS, 32'd36000, ST_OPENED, FULL_OPEN);
        send_request(MODE_STATUS, 32'd37000, ST_CLOSING, '0);
        send_request(MODE_STATUS, 32'd20037000, ST_CLOSED, '0);
        // zero open duration: the moving gate jumps to its end stop
        settle_block();
        set_run_durations('0, DUR_MAX);
        send_request(MODE_STATUS, 32'd20038000, ST_OPENING, '0);
        send_request(MODE_TICK, 32'd20038001, ST_OTHER, '0);
        clock_ms = 32'd20038001;

        // Random part: several duration settings, extremes first
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    open_ms  = DURATION_BITS'(1);
                    close_ms = DUR_MAX;
                end
                1: begin
                    open_ms  = DUR_MAX;
                    close_ms = DURATION_BITS'(1);
                end
                2: begin
                    open_ms  = DURATION_BITS'(RESET_RUN_MS);
                    close_ms = DURATION_BITS'(RESET_RUN_MS);
                end
                PHASES - 1: begin
                    open_ms  = DURATION_BITS'($urandom_range(1, DUR_MAX));
                    close_ms = DURATION_BITS'($urandom_range(1, DUR_MAX));
                end
                default: begin
                    open_ms  = DURATION_BITS'($urandom_range(20, 4000));
                    close_ms = DURATION_BITS'($urandom_range(20, 4000));
                end
            endcase
            // hold off the sender until everything is out, then reconfigure
            settle_block();
            set_run_durations(open_ms, close_ms);
            steady_flow = (phase == 2 || phase == 5);
            // take the millisecond clock across its wrap in one phase
            if (phase == 3) clock_ms = 32'hFFFF_F000;
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_REQUESTS) begin
                if ($urandom_range(0, 3) != 0) begin
                    clock_ms += $urandom_range(0, 500);
                    send_status(ST_CLOSED);
                    send_run(1'b1, open_ms);
                    clock_ms += $urandom_range(0, 500);
                    send_run(1'b0, close_ms);
                end else begin
                    repeat ($urandom_range(1, 4)) send_noise();
                end
            end
        end

        steady_flow = 1'b0;
        settle_block();
        if (mismatch_count == 0 && estimates_due == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
